@@ rtl/tslf_pkg.sv @@
// Package with the shared types, register indexes and character codes of the line formatter.
package tslf_pkg;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Up to four tail bytes follow the optional line number ("M-^X" is the longest).
   localparam int TAIL_MAX   = 4;
   localparam int TAIL_CNT_W = 3;
   localparam int TAIL_IDX_W = 2;

   // Depth of the queue between the classifier and the emitter.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // Line numbers are padded to at least this many characters.
   localparam int NUM_MIN_WIDTH = 6;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_NUMBER_ALL      = 3'd0,
      REG_NUMBER_NONBLANK = 3'd1,
      REG_SQUEEZE_BLANK   = 3'd2,
      REG_MARK_ENDS       = 3'd3,
      REG_SHOW_TABS       = 3'd4,
      REG_SHOW_NONPRINT   = 3'd5
   } reg_index_type;

   // Character codes.
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_DOLLAR   = 8'h24;
   localparam logic [7:0] CHAR_DASH     = 8'h2D;
   localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_LETTER_I = 8'h49;
   localparam logic [7:0] CHAR_LETTER_M = 8'h4D;
   localparam logic [7:0] CHAR_CARET    = 8'h5E;
   localparam logic [6:0] CHAR_DELETE   = 7'h7F;

   // Formatting modes as held by the configuration registers.
   typedef struct packed {
      logic number_all;
      logic number_nonblank;
      logic squeeze;
      logic mark_ends;
      logic show_tabs;
      logic show_nonprint;
   } cfg_type;

   // Bytes that follow the line number for one input byte.
   typedef struct packed {
      logic [TAIL_MAX-1:0][7:0] bytes;
      logic [TAIL_CNT_W-1:0]    count;
   } tail_type;

endpackage

@@ rtl/tslf_req_if.sv @@
// Stream interface that carries raw input bytes.
interface tslf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

@@ rtl/tslf_rsp_if.sv @@
// Stream interface that carries formatted output bytes.
interface tslf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

@@ rtl/tslf_csr.sv @@
// Configuration register file behind the APB-style port.
module tslf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tslf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tslf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tslf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output tslf_pkg::cfg_type              cfg
);

   tslf_pkg::cfg_type       cfg_ff;
   tslf_pkg::cfg_type       cfg_in;
   tslf_pkg::reg_index_type index;
   logic                    write_en;
   logic                    read_bit;

   assign index      = tslf_pkg::reg_index_type'(csr_paddr[4:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register write decode; indexes beyond the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            tslf_pkg::REG_NUMBER_ALL:      cfg_in.number_all      = csr_pwdata[0];
            tslf_pkg::REG_NUMBER_NONBLANK: cfg_in.number_nonblank = csr_pwdata[0];
            tslf_pkg::REG_SQUEEZE_BLANK:   cfg_in.squeeze         = csr_pwdata[0];
            tslf_pkg::REG_MARK_ENDS:       cfg_in.mark_ends       = csr_pwdata[0];
            tslf_pkg::REG_SHOW_TABS:       cfg_in.show_tabs       = csr_pwdata[0];
            tslf_pkg::REG_SHOW_NONPRINT:   cfg_in.show_nonprint   = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      case (index)
         tslf_pkg::REG_NUMBER_ALL:      read_bit = cfg_ff.number_all;
         tslf_pkg::REG_NUMBER_NONBLANK: read_bit = cfg_ff.number_nonblank;
         tslf_pkg::REG_SQUEEZE_BLANK:   read_bit = cfg_ff.squeeze;
         tslf_pkg::REG_MARK_ENDS:       read_bit = cfg_ff.mark_ends;
         tslf_pkg::REG_SHOW_TABS:       read_bit = cfg_ff.show_tabs;
         tslf_pkg::REG_SHOW_NONPRINT:   read_bit = cfg_ff.show_nonprint;
         default:                       read_bit = 1'b0;
      endcase
      csr_prdata = {{(tslf_pkg::CSR_DATA_W-1){1'b0}}, read_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/tslf_front.sv @@
// Front end: classifies each input byte, keeps line state and the BCD line counter.
module tslf_front #(
   parameter int COUNTER_DIGITS = 10,
   parameter int USED_W         = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tslf_pkg::cfg_type              cfg,
   input  logic                           accept,
   input  logic [7:0]                     data_byte,
   output logic                           push,
   output logic                           has_number,
   output tslf_pkg::tail_type             tail,
   output logic [USED_W-1:0]              used,
   output logic [COUNTER_DIGITS-1:0][3:0] digits
);

   logic                           at_line_start_ff, at_line_start_in;
   logic [1:0]                     blank_run_ff, blank_run_in;
   logic [COUNTER_DIGITS-1:0][3:0] digits_ff, digits_in;
   logic [USED_W-1:0]              used_ff, used_in;

   logic                           is_newline;
   logic                           blank_newline;
   logic [1:0]                     blank_run_inc;
   logic                           drop;
   logic                           count_up;
   logic [COUNTER_DIGITS-1:0]      nine;
   logic [COUNTER_DIGITS:0]        carry;
   logic                           all_nines;
   logic [COUNTER_DIGITS-1:0][3:0] digits_inc;
   logic [USED_W-1:0]              used_inc;
   logic [6:0]                     low7;
   logic [1:0][7:0]                vis_bytes;
   logic [1:0]                     vis_count;

   // Line classification.
   assign is_newline    = (data_byte == tslf_pkg::CHAR_NEWLINE);
   assign blank_newline = at_line_start_ff && is_newline;
   assign blank_run_inc = (blank_run_ff == 2'd3) ? 2'd3 : blank_run_ff + 2'd1;
   assign drop          = blank_newline && cfg.squeeze && (blank_run_inc > 2'd1);
   assign has_number    = blank_newline ? (cfg.number_all && !cfg.number_nonblank)
                                        : (at_line_start_ff &&
                                           (cfg.number_all || cfg.number_nonblank));
   assign push          = accept && !drop;
   assign count_up      = push && has_number;

   // A digit takes a carry when every digit below it is nine.
   always_comb begin
      for (int i = 0; i < COUNTER_DIGITS; i++) begin
         nine[i] = (digits_ff[i] == 4'd9);
      end
   end

   assign carry[0] = 1'b1;
   for (genvar g = 1; g <= COUNTER_DIGITS; g++) begin : g_carry
      assign carry[g] = &nine[g-1:0];
   end

   assign all_nines = carry[COUNTER_DIGITS];

   // Saturating BCD increment; the digit count grows when the carry passes the top used digit.
   always_comb begin
      for (int i = 0; i < COUNTER_DIGITS; i++) begin
         if (all_nines || !carry[i]) begin
            digits_inc[i] = digits_ff[i];
         end else if (nine[i]) begin
            digits_inc[i] = 4'd0;
         end else begin
            digits_inc[i] = digits_ff[i] + 4'd1;
         end
      end
      if (carry[used_ff] && !all_nines) begin
         used_inc = used_ff + USED_W'(1);
      end else begin
         used_inc = used_ff;
      end
   end

   assign digits = digits_inc;
   assign used   = used_inc;

   // Caret rendering of the low seven bits.
   assign low7 = data_byte[6:0];

   always_comb begin
      vis_bytes = '0;
      if (low7[6:5] == 2'b00) begin
         vis_bytes[0] = tslf_pkg::CHAR_CARET;
         vis_bytes[1] = {3'b010, low7[4:0]};
         vis_count    = 2'd2;
      end else if (low7 == tslf_pkg::CHAR_DELETE) begin
         vis_bytes[0] = tslf_pkg::CHAR_CARET;
         vis_bytes[1] = tslf_pkg::CHAR_QUESTION;
         vis_count    = 2'd2;
      end else begin
         vis_bytes[0] = {1'b0, low7};
         vis_count    = 2'd1;
      end
   end

   // Bytes emitted after the line number.
   always_comb begin
      tail = '0;
      if (is_newline) begin
         if (cfg.mark_ends) begin
            tail.bytes[0] = tslf_pkg::CHAR_DOLLAR;
            tail.bytes[1] = tslf_pkg::CHAR_NEWLINE;
            tail.count    = 3'd2;
         end else begin
            tail.bytes[0] = tslf_pkg::CHAR_NEWLINE;
            tail.count    = 3'd1;
         end
      end else if (data_byte == tslf_pkg::CHAR_TAB) begin
         if (cfg.show_tabs) begin
            tail.bytes[0] = tslf_pkg::CHAR_CARET;
            tail.bytes[1] = tslf_pkg::CHAR_LETTER_I;
            tail.count    = 3'd2;
         end else begin
            tail.bytes[0] = tslf_pkg::CHAR_TAB;
            tail.count    = 3'd1;
         end
      end else if (cfg.show_nonprint) begin
         if (data_byte[7]) begin
            tail.bytes[0] = tslf_pkg::CHAR_LETTER_M;
            tail.bytes[1] = tslf_pkg::CHAR_DASH;
            tail.bytes[2] = vis_bytes[0];
            tail.bytes[3] = vis_bytes[1];
            tail.count    = 3'd2 + {1'b0, vis_count};
         end else begin
            tail.bytes[0] = vis_bytes[0];
            tail.bytes[1] = vis_bytes[1];
            tail.count    = {1'b0, vis_count};
         end
      end else begin
         tail.bytes[0] = data_byte;
         tail.count    = 3'd1;
      end
   end

   // Next line state for an accepted byte.
   always_comb begin
      at_line_start_in = at_line_start_ff;
      blank_run_in     = blank_run_ff;
      digits_in        = digits_ff;
      used_in          = used_ff;
      if (accept) begin
         if (blank_newline) begin
            blank_run_in = blank_run_inc;
         end else begin
            if (at_line_start_ff) begin
               blank_run_in = 2'd0;
            end
            at_line_start_in = is_newline;
         end
      end
      if (count_up) begin
         digits_in = digits_inc;
         used_in   = used_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff <= 1'b1;
         blank_run_ff     <= 2'd0;
         digits_ff        <= '0;
         used_ff          <= USED_W'(1);
      end else begin
         at_line_start_ff <= at_line_start_in;
         blank_run_ff     <= blank_run_in;
         digits_ff        <= digits_in;
         used_ff          <= used_in;
      end
   end

endmodule

@@ rtl/tslf_queue.sv @@
// Small register FIFO that decouples the classifier from the emitter.
module tslf_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wdata,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0]                mem [tslf_pkg::QUEUE_DEPTH];
   logic [tslf_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tslf_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tslf_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == tslf_pkg::QUEUE_CNT_W'(tslf_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + tslf_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + tslf_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + tslf_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - tslf_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/tslf_back.sv @@
// Back end: walks one queued entry, one byte per cycle into the output register unless stalled.
module tslf_back #(
   parameter int COUNTER_DIGITS = 10,
   parameter int USED_W         = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           empty,
   input  logic                           has_number,
   input  tslf_pkg::tail_type             tail,
   input  logic [USED_W-1:0]              used,
   input  logic [COUNTER_DIGITS-1:0][3:0] digits,
   output logic                           pop,
   input  logic                           out_ready,
   output logic                           out_valid,
   output logic [7:0]                     out_byte,
   output logic                           last_of_run
);

   localparam int POS_W = $clog2(COUNTER_DIGITS + tslf_pkg::TAIL_MAX + 2);
   localparam int IDX_W = $clog2(COUNTER_DIGITS);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;

   logic [POS_W-1:0] used_ext;
   logic [POS_W-1:0] width;
   logic [POS_W-1:0] num_len;
   logic [POS_W-1:0] total;
   logic [POS_W-1:0] digit_pos;
   logic [POS_W-1:0] tail_pos;
   logic             step;
   logic             is_last;
   logic [7:0]       byte_sel;

   assign out_valid   = valid_ff;
   assign out_byte    = byte_ff;
   assign last_of_run = last_ff;

   // Run length of the head entry.
   assign used_ext  = POS_W'(used);
   assign width     = (used_ext < POS_W'(tslf_pkg::NUM_MIN_WIDTH))
                      ? POS_W'(tslf_pkg::NUM_MIN_WIDTH) : used_ext;
   assign num_len   = has_number ? width + POS_W'(1) : '0;
   assign total     = num_len + POS_W'(tail.count);
   assign digit_pos = width - POS_W'(1) - pos_ff;
   assign tail_pos  = pos_ff - num_len;
   assign is_last   = (pos_ff == total - POS_W'(1));
   assign step      = !empty && (!valid_ff || out_ready);
   assign pop       = step && is_last;

   // Byte at the current position: padded digits, tab, then the tail bytes.
   always_comb begin
      if (has_number && (pos_ff < width)) begin
         if (digit_pos >= used_ext) begin
            byte_sel = tslf_pkg::CHAR_SPACE;
         end else begin
            byte_sel = {tslf_pkg::CHAR_DIGIT_HI, digits[digit_pos[IDX_W-1:0]]};
         end
      end else if (has_number && (pos_ff == width)) begin
         byte_sel = tslf_pkg::CHAR_TAB;
      end else begin
         byte_sel = tail.bytes[tail_pos[tslf_pkg::TAIL_IDX_W-1:0]];
      end
   end

   // Output register and position counter.
   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (step) begin
         valid_in = 1'b1;
         byte_in  = byte_sel;
         last_in  = is_last;
         pos_in   = is_last ? '0 : pos_ff + POS_W'(1);
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

@@ rtl/text_stream_line_formatter_top.sv @@
// Top level of the cat-style text stream line formatter.
//
// Each accepted input byte produces zero to COUNTER_DIGITS+5 output bytes: an optional
// line number (right-aligned, space-padded to at least six digits, then a tab) and then
// one to four bytes for the character; last_of_run marks the final byte of each run. A
// squeezed blank line produces no output at all. The front end takes one byte per cycle
// while the four-entry queue has room, and the back end emits one output byte per cycle
// while the output is accepted; a plain byte yields one output byte, an escaped byte up to
// four, and a numbered line start adds seven or more bytes. The line counter is a BCD counter
// of COUNTER_DIGITS digits that holds at all nines. Modes are set through the register port
// and should be changed only while the block is idle.
module text_stream_line_formatter_top #(
   parameter int COUNTER_DIGITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   tslf_req_if.sink                        req_stream,
   tslf_rsp_if.source                      rsp_stream,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tslf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tslf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tslf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int USED_W  = $clog2(COUNTER_DIGITS + 1);
   localparam int DIG_W   = 4 * COUNTER_DIGITS;
   localparam int TAIL_W  = $bits(tslf_pkg::tail_type);
   localparam int ENTRY_W = 1 + TAIL_W + USED_W + DIG_W;

   tslf_pkg::cfg_type              cfg;
   logic                           accept;
   logic                           push;
   logic                           pop;
   logic                           full;
   logic                           empty;
   logic                           f_has_number;
   tslf_pkg::tail_type             f_tail;
   logic [USED_W-1:0]              f_used;
   logic [COUNTER_DIGITS-1:0][3:0] f_digits;
   logic [ENTRY_W-1:0]             wdata;
   logic [ENTRY_W-1:0]             rdata;
   logic                           b_has_number;
   tslf_pkg::tail_type             b_tail;
   logic [USED_W-1:0]              b_used;
   logic [COUNTER_DIGITS-1:0][3:0] b_digits;

   // Input transaction accepted whenever the queue has room.
   assign req_stream.ready = !full;
   assign accept           = req_stream.valid && !full;

   tslf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tslf_front #(
      .COUNTER_DIGITS (COUNTER_DIGITS),
      .USED_W         (USED_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .data_byte  (req_stream.data_byte),
      .push       (push),
      .has_number (f_has_number),
      .tail       (f_tail),
      .used       (f_used),
      .digits     (f_digits)
   );

   // Queue entry packing.
   assign wdata = {f_has_number, f_tail, f_used, f_digits};
   assign {b_has_number, b_tail, b_used, b_digits} = rdata;

   tslf_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (wdata),
      .pop   (pop),
      .full  (full),
      .empty (empty),
      .rdata (rdata)
   );

   tslf_back #(
      .COUNTER_DIGITS (COUNTER_DIGITS),
      .USED_W         (USED_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .empty       (empty),
      .has_number  (b_has_number),
      .tail        (b_tail),
      .used        (b_used),
      .digits      (b_digits),
      .pop         (pop),
      .out_ready   (rsp_stream.ready),
      .out_valid   (rsp_stream.valid),
      .out_byte    (rsp_stream.out_byte),
      .last_of_run (rsp_stream.last_of_run)
   );

endmodule
